// ===== hdl/ackermann_wheel_angle_split_defines.svh =====
// ----------------------------------------------------------------------------
// ackermann_wheel_angle_split_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ACKERMANN_WHEEL_ANGLE_SPLIT_DEFINES_SVH
`define ACKERMANN_WHEEL_ANGLE_SPLIT_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define AWA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wheel angle check failed");

// Property that must hold in the cycle after its antecedent.
`define AWA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wheel angle check failed");

`endif

// ===== hdl/awa_pkg.sv =====
// ----------------------------------------------------------------------------
// awa_pkg
// Types, constants and tables for the Ackermann wheel angle pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awa_pkg;

  localparam int CORDIC_STAGES = 16;

  localparam int ZW = 35;   // rotation angle, Q30 radians
  localparam int RW = 35;   // sine and cosine, Q30
  localparam int PW = 53;   // products of a length and a sine or cosine
  localparam int NW = 54;   // numerator and denominators
  localparam int MW = 60;   // normalized magnitudes
  localparam int VW = 64;   // vectoring x and y
  localparam int AW = 33;   // vectoring angle, Q30 radians
  localparam int OW = 15;   // wheel angle, Q2.13 radians

  localparam logic signed [ZW-1:0] HALF_PI_Q30  = 35'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30       = 35'sd3373259426;
  localparam logic signed [RW-1:0] INV_GAIN_Q30 = 35'sd652032874;
  localparam logic signed [AW-1:0] HALF_PI_Z    = 33'sd1686629713;
  localparam logic signed [OW-1:0] HALF_PI_Q13  = 15'sd12868;
  localparam logic signed [AW-1:0] ROUND_HALF   = 33'sd65536;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    CFG_WHEELBASE    = 2'd0,
    CFG_TRACK_WIDTH  = 2'd1,
    CFG_ANGLE_LIMIT  = 2'd2,
    CFG_CLAMP_RADIUS = 2'd3
  } cfg_idx_t;

  // Side information that rides along with an angle through the rotator.
  typedef struct packed {
    logic clamp;   // magnitude above the limit
    logic neg;     // steering angle negative
    logic zero;    // steering angle exactly zero
  } tag_t;

  // Special cases of one arctangent lane.
  typedef struct packed {
    logic num_zero;
    logic den_zero;
    logic num_pos;
    logic neg;
  } lane_flag_t;

  typedef struct packed {
    logic [MW-1:0] m;
    logic [MW-1:0] un;
    logic [MW-1:0] ud;
  } nrm_t;

  // One step of the normalizing shift: move by k when that stays below 2^59.
  function automatic nrm_t norm_step(nrm_t v, int k);
    nrm_t r;
    r = v;
    if (v.m < ({{(MW-1){1'b0}}, 1'b1} << (59 - k))) begin
      r.m  = v.m << k;
      r.un = v.un << k;
      r.ud = v.ud << k;
    end
    return r;
  endfunction

endpackage

// ===== hdl/awa_sincos.sv =====
// ----------------------------------------------------------------------------
// awa_sincos
// Pipelined CORDIC rotator: one stage per iteration, gives sine and cosine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awa_sincos (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_v,
  input  awa_pkg::tag_t                       in_tag,
  input  logic signed [awa_pkg::ZW-1:0]       in_z,
  output logic                                out_v,
  output awa_pkg::tag_t                       out_tag,
  output logic signed [awa_pkg::RW-1:0]       out_s,
  output logic signed [awa_pkg::RW-1:0]       out_c
);

  localparam int N = awa_pkg::CORDIC_STAGES;

  logic                          v_r   [N];
  awa_pkg::tag_t                 tag_r [N];
  logic signed [awa_pkg::RW-1:0] x_r   [N];
  logic signed [awa_pkg::RW-1:0] y_r   [N];
  logic signed [awa_pkg::ZW-1:0] z_r   [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic                          pv;
      awa_pkg::tag_t                 ptag;
      logic signed [awa_pkg::RW-1:0] px, py, x_nxt, y_nxt;
      logic signed [awa_pkg::ZW-1:0] pz, z_nxt, at;

      if (i == 0) begin : g_first
        assign pv   = in_v;
        assign ptag = in_tag;
        assign px   = awa_pkg::INV_GAIN_Q30;
        assign py   = '0;
        assign pz   = in_z;
      end else begin : g_next
        assign pv   = v_r[i-1];
        assign ptag = tag_r[i-1];
        assign px   = x_r[i-1];
        assign py   = y_r[i-1];
        assign pz   = z_r[i-1];
      end

      assign at = $signed({{(awa_pkg::ZW-32){1'b0}}, awa_pkg::ATAN_TAB[i]});

      always_comb begin
        if (pz >= 0) begin
          x_nxt = px - (py >>> i);
          y_nxt = py + (px >>> i);
          z_nxt = pz - at;
        end else begin
          x_nxt = px + (py >>> i);
          y_nxt = py - (px >>> i);
          z_nxt = pz + at;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en) begin
          v_r[i] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          tag_r[i] <= ptag;
          x_r[i]   <= x_nxt;
          y_r[i]   <= y_nxt;
          z_r[i]   <= z_nxt;
        end
      end
    end
  endgenerate

  assign out_v   = v_r[N-1];
  assign out_tag = tag_r[N-1];
  assign out_s   = y_r[N-1];
  assign out_c   = x_r[N-1];

endmodule

// ===== hdl/awa_atan.sv =====
// ----------------------------------------------------------------------------
// awa_atan
// One wheel lane: normalizes a ratio, runs a pipelined CORDIC vectoring pass
// and rounds the angle to Q2.13 with saturation at pi/2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awa_atan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic signed [awa_pkg::NW-1:0] in_num,
  input  logic signed [awa_pkg::NW-1:0] in_den,
  output logic                          out_v,
  output logic signed [awa_pkg::OW-1:0] out_angle
);

  localparam int N = awa_pkg::CORDIC_STAGES;

  // Magnitudes and special cases.
  logic                  n_v_r [4];
  awa_pkg::lane_flag_t   n_f_r [4];
  awa_pkg::nrm_t         n_d_r [4];

  logic [awa_pkg::NW-1:0] un_w, ud_w;
  awa_pkg::nrm_t          n0_nxt;
  awa_pkg::lane_flag_t    f0_nxt;

  always_comb begin
    un_w = in_num[awa_pkg::NW-1] ? (~in_num + {{(awa_pkg::NW-1){1'b0}}, 1'b1}) : in_num;
    ud_w = in_den[awa_pkg::NW-1] ? (~in_den + {{(awa_pkg::NW-1){1'b0}}, 1'b1}) : in_den;
    n0_nxt.un = {{(awa_pkg::MW-awa_pkg::NW){1'b0}}, un_w};
    n0_nxt.ud = {{(awa_pkg::MW-awa_pkg::NW){1'b0}}, ud_w};
    n0_nxt.m  = (un_w > ud_w) ? n0_nxt.un : n0_nxt.ud;
    f0_nxt.num_zero = (in_num == '0);
    f0_nxt.den_zero = (in_den == '0);
    f0_nxt.num_pos  = !in_num[awa_pkg::NW-1];
    f0_nxt.neg      = in_num[awa_pkg::NW-1] ^ in_den[awa_pkg::NW-1];
  end

  // The shift is found greedily, two binary steps per stage.
  awa_pkg::nrm_t n_nxt [4];
  assign n_nxt[0] = n0_nxt;
  assign n_nxt[1] = awa_pkg::norm_step(awa_pkg::norm_step(n_d_r[0], 32), 16);
  assign n_nxt[2] = awa_pkg::norm_step(awa_pkg::norm_step(n_d_r[1], 8), 4);
  assign n_nxt[3] = awa_pkg::norm_step(awa_pkg::norm_step(n_d_r[2], 2), 1);

  genvar j;
  generate
    for (j = 0; j < 4; j++) begin : g_norm
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          n_v_r[j] <= 1'b0;
        end else if (en) begin
          n_v_r[j] <= (j == 0) ? in_v : n_v_r[(j == 0) ? 0 : j-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          n_f_r[j] <= (j == 0) ? f0_nxt : n_f_r[(j == 0) ? 0 : j-1];
          n_d_r[j] <= n_nxt[j];
        end
      end
    end
  endgenerate

  // Vectoring pipeline.
  logic                          v_r [N];
  awa_pkg::lane_flag_t           f_r [N];
  logic signed [awa_pkg::VW-1:0] x_r [N];
  logic signed [awa_pkg::VW-1:0] y_r [N];
  logic signed [awa_pkg::AW-1:0] z_r [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic                          pv;
      awa_pkg::lane_flag_t           pf;
      logic signed [awa_pkg::VW-1:0] px, py, x_nxt, y_nxt;
      logic signed [awa_pkg::AW-1:0] pz, z_nxt, at;

      if (i == 0) begin : g_first
        assign pv = n_v_r[3];
        assign pf = n_f_r[3];
        assign px = $signed({{(awa_pkg::VW-awa_pkg::MW){1'b0}}, n_d_r[3].ud});
        assign py = $signed({{(awa_pkg::VW-awa_pkg::MW){1'b0}}, n_d_r[3].un});
        assign pz = '0;
      end else begin : g_next
        assign pv = v_r[i-1];
        assign pf = f_r[i-1];
        assign px = x_r[i-1];
        assign py = y_r[i-1];
        assign pz = z_r[i-1];
      end

      assign at = $signed({{(awa_pkg::AW-32){1'b0}}, awa_pkg::ATAN_TAB[i]});

      always_comb begin
        if (py >= 0) begin
          x_nxt = px + (py >>> i);
          y_nxt = py - (px >>> i);
          z_nxt = pz + at;
        end else begin
          x_nxt = px - (py >>> i);
          y_nxt = py + (px >>> i);
          z_nxt = pz - at;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en) begin
          v_r[i] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          f_r[i] <= pf;
          x_r[i] <= x_nxt;
          y_r[i] <= y_nxt;
          z_r[i] <= z_nxt;
        end
      end
    end
  endgenerate

  // Clamp, round and apply the sign.
  logic signed [awa_pkg::AW-1:0] zc, zr;
  logic signed [awa_pkg::OW-1:0] mag, angle_nxt;
  logic                          out_v_r;
  logic signed [awa_pkg::OW-1:0] angle_r;

  always_comb begin
    zc = z_r[N-1];
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > awa_pkg::HALF_PI_Z) begin
      zc = awa_pkg::HALF_PI_Z;
    end
    zr  = (zc + awa_pkg::ROUND_HALF) >>> 17;
    mag = zr[awa_pkg::OW-1:0];
    if (f_r[N-1].num_zero) begin
      angle_nxt = '0;
    end else if (f_r[N-1].den_zero) begin
      angle_nxt = f_r[N-1].num_pos ? awa_pkg::HALF_PI_Q13 : -awa_pkg::HALF_PI_Q13;
    end else begin
      angle_nxt = f_r[N-1].neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_v     = out_v_r;
  assign out_angle = angle_r;

endmodule

// ===== hdl/ackermann_wheel_angle_split.sv =====
// ----------------------------------------------------------------------------
// ackermann_wheel_angle_split
// Left and right front wheel angles from one central steering angle.
// ----------------------------------------------------------------------------
// The block accepts one steering request per clock cycle while no finished
// result waits on out_ready, and returns the matching wheel angle pair after
// one input stage, the rotation CORDIC, two multiply and add stages, four
// normalizing stages, the vectoring CORDIC and a rounding stage.
// Every stage holds while a finished result waits on out_ready, so a stall
// loses nothing. The configuration registers must only be written while no
// request is in flight.
`timescale 1ns / 1ps

module ackermann_wheel_angle_split (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_steer_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [awa_pkg::OW-1:0] out_left_wheel_angle,
  output logic signed [awa_pkg::OW-1:0] out_right_wheel_angle,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  logic [15:0] wheelbase_r, track_width_r, clamp_radius_r;
  logic [13:0] angle_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheelbase_r    <= 16'd2867;
      track_width_r  <= 16'd2212;
      angle_limit_r  <= 14'd9830;
      clamp_radius_r <= 16'd4915;
    end else if (cfg_we) begin
      unique case (awa_pkg::cfg_idx_t'(cfg_index))
        awa_pkg::CFG_WHEELBASE:    wheelbase_r    <= cfg_wdata;
        awa_pkg::CFG_TRACK_WIDTH:  track_width_r  <= cfg_wdata;
        awa_pkg::CFG_ANGLE_LIMIT:  angle_limit_r  <= cfg_wdata[13:0];
        awa_pkg::CFG_CLAMP_RADIUS: clamp_radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Input stage: limit test and reduction of the angle into [-pi/2, pi/2].
  logic [16:0]                   mag;
  logic signed [awa_pkg::ZW-1:0] z_full, z_nxt;
  awa_pkg::tag_t                 tag_nxt;
  logic                          p_v_r;
  awa_pkg::tag_t                 p_tag_r;
  logic signed [awa_pkg::ZW-1:0] p_z_r;

  always_comb begin
    mag = in_steer_angle[15] ? (17'd0 - {1'b1, in_steer_angle})
                             : {1'b0, in_steer_angle};
    z_full = {{(awa_pkg::ZW-33){in_steer_angle[15]}}, in_steer_angle, 17'd0};
    if (z_full > awa_pkg::HALF_PI_Q30) begin
      z_nxt = z_full - awa_pkg::PI_Q30;
    end else if (z_full < -awa_pkg::HALF_PI_Q30) begin
      z_nxt = z_full + awa_pkg::PI_Q30;
    end else begin
      z_nxt = z_full;
    end
    tag_nxt.clamp = mag > {3'd0, angle_limit_r};
    tag_nxt.neg   = in_steer_angle[15];
    tag_nxt.zero  = (in_steer_angle == 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_tag_r <= tag_nxt;
      p_z_r   <= z_nxt;
    end
  end

  logic                          sc_v;
  awa_pkg::tag_t                 sc_tag;
  logic signed [awa_pkg::RW-1:0] sc_s, sc_c;

  awa_sincos u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (p_v_r),
    .in_tag  (p_tag_r),
    .in_z    (p_z_r),
    .out_v   (sc_v),
    .out_tag (sc_tag),
    .out_s   (sc_s),
    .out_c   (sc_c)
  );

  // Multiply stage.
  logic signed [17:0]            l2, tw;
  logic signed [awa_pkg::RW-1:0] s_eff;
  logic signed [awa_pkg::PW-1:0] l2_x, tw_x, s_x, c_x;
  logic                          m_v_r;
  awa_pkg::tag_t                 m_tag_r;
  logic signed [awa_pkg::PW-1:0] p_ls_r, p_lc_r, p_ts_r;

  assign l2    = $signed({1'b0, wheelbase_r, 1'b0});
  assign tw    = $signed({2'b00, track_width_r});
  assign s_eff = sc_tag.zero ? '0 : sc_s;
  assign l2_x  = {{(awa_pkg::PW-18){l2[17]}}, l2};
  assign tw_x  = {{(awa_pkg::PW-18){tw[17]}}, tw};
  assign s_x   = {{(awa_pkg::PW-awa_pkg::RW){s_eff[awa_pkg::RW-1]}}, s_eff};
  assign c_x   = {{(awa_pkg::PW-awa_pkg::RW){sc_c[awa_pkg::RW-1]}}, sc_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= sc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tag_r <= sc_tag;
      p_ls_r  <= l2_x * s_x;
      p_lc_r  <= l2_x * c_x;
      p_ts_r  <= tw_x * s_x;
    end
  end

  // Add stage: ratio terms for both wheels, or the clamp radius terms.
  logic signed [awa_pkg::NW-1:0] r2, tn, num_nxt, den_l_nxt, den_r_nxt;
  logic                          a_v_r;
  logic signed [awa_pkg::NW-1:0] num_r, den_l_r, den_r_r;

  always_comb begin
    tn = {{(awa_pkg::NW-18){1'b0}}, tw};
    r2 = {{(awa_pkg::NW-17){1'b0}}, clamp_radius_r, 1'b0};
    if (m_tag_r.neg) begin
      r2 = -r2;
    end
    if (m_tag_r.clamp) begin
      num_nxt   = {{(awa_pkg::NW-18){1'b0}}, l2};
      den_l_nxt = r2 - tn;
      den_r_nxt = r2 + tn;
    end else begin
      num_nxt   = {{(awa_pkg::NW-awa_pkg::PW){p_ls_r[awa_pkg::PW-1]}}, p_ls_r};
      den_l_nxt = {{(awa_pkg::NW-awa_pkg::PW){p_lc_r[awa_pkg::PW-1]}}, p_lc_r}
                - {{(awa_pkg::NW-awa_pkg::PW){p_ts_r[awa_pkg::PW-1]}}, p_ts_r};
      den_r_nxt = {{(awa_pkg::NW-awa_pkg::PW){p_lc_r[awa_pkg::PW-1]}}, p_lc_r}
                + {{(awa_pkg::NW-awa_pkg::PW){p_ts_r[awa_pkg::PW-1]}}, p_ts_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r   <= num_nxt;
      den_l_r <= den_l_nxt;
      den_r_r <= den_r_nxt;
    end
  end

  logic left_v, right_v;

  awa_atan u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (a_v_r),
    .in_num    (num_r),
    .in_den    (den_l_r),
    .out_v     (left_v),
    .out_angle (out_left_wheel_angle)
  );

  awa_atan u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (a_v_r),
    .in_num    (num_r),
    .in_den    (den_r_r),
    .out_v     (right_v),
    .out_angle (out_right_wheel_angle)
  );

  // Both lanes run in lockstep, so either valid bit serves.
  assign out_valid = left_v & right_v;

endmodule

// ===== hdl/awa_checker.sv =====
// ----------------------------------------------------------------------------
// awa_checker
// Port-level checks for the wheel angle pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ackermann_wheel_angle_split_defines.svh"

module awa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [awa_pkg::OW-1:0] out_left_wheel_angle,
  input logic signed [awa_pkg::OW-1:0] out_right_wheel_angle
);

  `AWA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left_wheel_angle) && $stable(out_right_wheel_angle))
  `AWA_ASSERT_NOW(a_stall_back, out_valid && !out_ready, !in_ready)
  `AWA_ASSERT_NOW(a_left_range, out_valid, out_left_wheel_angle <= awa_pkg::HALF_PI_Q13 && out_left_wheel_angle >= -awa_pkg::HALF_PI_Q13)
  `AWA_ASSERT_NOW(a_right_range, out_valid, out_right_wheel_angle <= awa_pkg::HALF_PI_Q13 && out_right_wheel_angle >= -awa_pkg::HALF_PI_Q13)

endmodule

bind ackermann_wheel_angle_split awa_checker u_awa_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_left_wheel_angle  (out_left_wheel_angle),
  .out_right_wheel_angle (out_right_wheel_angle)
);
